FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/alc_pkg.sv
// ----------------------------------------------------------------------------
// alc_pkg
// Widths, constants and beat types of the layer cycle advance pipeline.
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int unsigned FracBits = 16;            // fraction bits of Q values
  localparam int unsigned PlayFrac = 10;            // fraction bits of play rate
  localparam int unsigned QW       = FracBits + 1;  // Q0.F value incl. 1.0
  localparam int unsigned RateW    = FracBits + 8;
  localparam int unsigned PlayW    = 16;
  localparam int unsigned SeqW     = 9;
  localparam int unsigned PW       = RateW;                   // (dt*rate)>>F
  localparam int unsigned DmagW    = PW + PlayW - PlayFrac;   // advance magnitude
  localparam int unsigned CW       = DmagW + 2;               // signed raw cycle

  localparam int unsigned AdvStages = 4;
  localparam int unsigned DivStages = FracBits;     // one quotient bit per stage
  localparam int unsigned SmStages  = 3;
  localparam int unsigned PipeDepth = AdvStages + DivStages + SmStages;

  localparam logic [QW-1:0] OneQ = {1'b1, {FracBits{1'b0}}};

  typedef struct packed {
    logic [QW-1:0]           cycle_now;
    logic [FracBits-1:0]     tick_interval;
    logic [RateW-1:0]        seq_cycle_rate;
    logic signed [PlayW-1:0] play_rate;
    logic                    loops;
    logic                    auto_ramp;
    logic [QW-1:0]           ramp_in;
    logic [QW-1:0]           ramp_out;
    logic [SeqW-1:0]         seq_id;
    logic [QW-1:0]           weight_now;
  } alc_in_t;

  typedef struct packed {
    logic [QW-1:0] cycle_next;
    logic          finished;
    logic [QW-1:0] weight_next;
  } alc_out_t;

  // fields carried unchanged past the ramp divide
  typedef struct packed {
    logic [QW-1:0] cycle;
    logic          finished;
    logic          auto_ramp;
    logic          seq_zero;
    logic [QW-1:0] weight_now;
  } alc_side_t;

  typedef struct packed {
    alc_side_t     side;
    logic          full_one;
    logic [QW-1:0] num;
    logic [QW-1:0] den;
  } alc_div_t;

  typedef struct packed {
    alc_side_t     side;
    logic [QW-1:0] w;
  } alc_wgt_t;

endpackage

FILE: hw/rtl/alc_advance.sv
// ----------------------------------------------------------------------------
// alc_advance
// Four stages: rate product, play rate product, signed add, wrap/clamp and
// ramp selection.
// ----------------------------------------------------------------------------
module alc_advance (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  alc_pkg::alc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output alc_pkg::alc_div_t out_data_o
);
  import alc_pkg::*;

  localparam int unsigned Prod1W = FracBits + RateW;
  localparam int unsigned Prod2W = PW + PlayW;

  typedef struct packed {
    logic [QW-1:0] cyc;
    logic          loops;
    logic          auto_ramp;
    logic [QW-1:0] ramp_in;
    logic [QW-1:0] ramp_out;
    logic          seq_zero;
    logic [QW-1:0] weight_now;
  } adv_pass_t;

  logic [AdvStages-1:0] v_q;
  logic [AdvStages:0]   rdy_chain;
  logic [AdvStages-1:0] v_src;

  assign rdy_chain[AdvStages] = out_ready_i;
  for (genvar k = 0; k < AdvStages; k++) begin : g_rdy
    assign rdy_chain[k] = !v_q[k] || rdy_chain[k+1];
  end
  assign v_src = {v_q[AdvStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < AdvStages; k++) begin
        if (rdy_chain[k]) begin
          v_q[k] <= v_src[k];
        end
      end
    end
  end

  // stage 1: p = (dt * rate) >> F, play rate magnitude
  logic [Prod1W-1:0] prod1;
  logic [PlayW-1:0]  pr_bits;
  logic [PlayW-1:0]  pmag_d;
  adv_pass_t         pass_d;
  logic [PW-1:0]     p_q;
  logic [PlayW-1:0]  pmag_q;
  logic              neg1_q;
  adv_pass_t         pass1_q;

  always_comb begin
    prod1   = Prod1W'(in_data_i.tick_interval) * Prod1W'(in_data_i.seq_cycle_rate);
    pr_bits = unsigned'(in_data_i.play_rate);
    pmag_d  = pr_bits[PlayW-1] ? PlayW'(~pr_bits + PlayW'(1)) : pr_bits;
    pass_d.cyc        = in_data_i.cycle_now;
    pass_d.loops      = in_data_i.loops;
    pass_d.auto_ramp  = in_data_i.auto_ramp;
    pass_d.ramp_in    = in_data_i.ramp_in;
    pass_d.ramp_out   = in_data_i.ramp_out;
    pass_d.seq_zero   = (in_data_i.seq_id == '0);
    pass_d.weight_now = in_data_i.weight_now;
  end

  always_ff @(posedge clk_i) begin
    if (rdy_chain[0]) begin
      p_q     <= prod1[FracBits +: PW];
      pmag_q  <= pmag_d;
      neg1_q  <= pr_bits[PlayW-1];
      pass1_q <= pass_d;
    end
  end

  // stage 2: advance magnitude, truncated toward zero
  logic [Prod2W-1:0] prod2;
  logic [DmagW-1:0]  dmag_q;
  logic              neg2_q;
  adv_pass_t         pass2_q;

  assign prod2 = Prod2W'(p_q) * Prod2W'(pmag_q);

  always_ff @(posedge clk_i) begin
    if (rdy_chain[1]) begin
      dmag_q  <= prod2[PlayFrac +: DmagW];
      neg2_q  <= neg1_q;
      pass2_q <= pass1_q;
    end
  end

  // stage 3: signed raw cycle
  logic [CW-1:0] cyc_ext;
  logic [CW-1:0] dmag_ext;
  logic [CW-1:0] c_q;
  adv_pass_t     pass3_q;

  assign cyc_ext  = CW'(pass2_q.cyc);
  assign dmag_ext = CW'(dmag_q);

  always_ff @(posedge clk_i) begin
    if (rdy_chain[2]) begin
      c_q     <= neg2_q ? (cyc_ext - dmag_ext) : (cyc_ext + dmag_ext);
      pass3_q <= pass2_q;
    end
  end

  // stage 4: floor wrap or clamp, then pick the ramp ratio operands
  logic          c_neg;
  logic          c_ge;
  logic [QW-1:0] c_frac;
  logic [QW-1:0] c_fix;
  logic [QW:0]   sum_out;
  logic          hit_in;
  logic          hit_out;
  alc_div_t      s4_d;
  alc_div_t      s4_q;

  always_comb begin
    c_neg  = c_q[CW-1];
    c_ge   = !c_neg && (c_q[CW-2:FracBits] != '0);
    c_frac = {1'b0, c_q[FracBits-1:0]};
    if (c_neg) begin
      c_fix = pass3_q.loops ? c_frac : '0;
    end else if (c_ge) begin
      c_fix = pass3_q.loops ? c_frac : OneQ;
    end else begin
      c_fix = c_q[QW-1:0];
    end
    sum_out = (QW+1)'(c_fix) + (QW+1)'(pass3_q.ramp_out);
    hit_out = (pass3_q.ramp_out != '0) && (sum_out > (QW+1)'(OneQ));
    hit_in  = (pass3_q.ramp_in != '0) && (c_fix < pass3_q.ramp_in);

    s4_d.side.cycle      = c_fix;
    s4_d.side.finished   = c_ge;
    s4_d.side.auto_ramp  = pass3_q.auto_ramp;
    s4_d.side.seq_zero   = pass3_q.seq_zero;
    s4_d.side.weight_now = pass3_q.weight_now;
    // blend out wins over blend in
    if (hit_out) begin
      s4_d.full_one = 1'b0;
      s4_d.num      = OneQ - c_fix;
      s4_d.den      = pass3_q.ramp_out;
    end else if (hit_in) begin
      s4_d.full_one = 1'b0;
      s4_d.num      = c_fix;
      s4_d.den      = pass3_q.ramp_in;
    end else begin
      s4_d.full_one = 1'b1;
      s4_d.num      = '0;
      s4_d.den      = OneQ;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_chain[3]) begin
      s4_q <= s4_d;
    end
  end

  assign in_ready_o  = rdy_chain[0];
  assign out_valid_o = v_q[AdvStages-1];
  assign out_data_o  = s4_q;

endmodule

FILE: hw/rtl/alc_divider.sv
// ----------------------------------------------------------------------------
// alc_divider
// Pipelined restoring divide, one quotient bit per stage: (num << F) / den
// with num below den.
// ----------------------------------------------------------------------------
module alc_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  alc_pkg::alc_div_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output alc_pkg::alc_wgt_t out_data_o
);
  import alc_pkg::*;

  typedef struct packed {
    alc_side_t           side;
    logic                full_one;
    logic [QW-1:0]       den;
    logic [QW-1:0]       rem;
    logic [FracBits-1:0] quo;
  } div_stage_t;

  logic [DivStages-1:0] v_q;
  logic [DivStages:0]   rdy_chain;
  logic [DivStages-1:0] v_src;
  div_stage_t           st_src [DivStages];
  div_stage_t           st_q   [DivStages];

  assign rdy_chain[DivStages] = out_ready_i;
  for (genvar k = 0; k < DivStages; k++) begin : g_rdy
    assign rdy_chain[k] = !v_q[k] || rdy_chain[k+1];
  end
  assign v_src = {v_q[DivStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < DivStages; k++) begin
        if (rdy_chain[k]) begin
          v_q[k] <= v_src[k];
        end
      end
    end
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_step
    logic [QW:0] rem2;
    logic [QW:0] den_x;
    logic        ge;
    logic [QW:0] rem_n;
    div_stage_t  st_d;

    if (k == 0) begin : g_first
      always_comb begin
        st_src[k].side     = in_data_i.side;
        st_src[k].full_one = in_data_i.full_one;
        st_src[k].den      = in_data_i.den;
        st_src[k].rem      = in_data_i.num;
        st_src[k].quo      = '0;
      end
    end else begin : g_rest
      assign st_src[k] = st_q[k-1];
    end

    always_comb begin
      rem2  = {st_src[k].rem, 1'b0};
      den_x = {1'b0, st_src[k].den};
      ge    = (rem2 >= den_x);
      rem_n = ge ? (rem2 - den_x) : rem2;
      st_d          = st_src[k];
      st_d.rem      = rem_n[QW-1:0];  // stays below den
      st_d.quo      = {st_src[k].quo[FracBits-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (rdy_chain[k]) begin
        st_q[k] <= st_d;
      end
    end
  end

  assign in_ready_o      = rdy_chain[0];
  assign out_valid_o     = v_q[DivStages-1];
  assign out_data_o.side = st_q[DivStages-1].side;
  assign out_data_o.w    = st_q[DivStages-1].full_one ? OneQ
                                                       : {1'b0, st_q[DivStages-1].quo};

endmodule

FILE: hw/rtl/alc_smooth.sv
// ----------------------------------------------------------------------------
// alc_smooth
// Smoothstep 3w^2 - 2w^3 over three stages, saturation and weight select.
// The last stage is the block's output register.
// ----------------------------------------------------------------------------
module alc_smooth (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  alc_pkg::alc_wgt_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output alc_pkg::alc_out_t out_data_o
);
  import alc_pkg::*;

  localparam int unsigned MulW = 2 * QW;
  localparam int unsigned SW   = QW + 3;  // signed smoothstep sum

  logic [SmStages-1:0] v_q;
  logic [SmStages:0]   rdy_chain;
  logic [SmStages-1:0] v_src;

  assign rdy_chain[SmStages] = out_ready_i;
  for (genvar k = 0; k < SmStages; k++) begin : g_rdy
    assign rdy_chain[k] = !v_q[k] || rdy_chain[k+1];
  end
  assign v_src = {v_q[SmStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < SmStages; k++) begin
        if (rdy_chain[k]) begin
          v_q[k] <= v_src[k];
        end
      end
    end
  end

  // stage 1: w2 = (w*w) >> F
  logic [MulW-1:0] prod_a;
  logic [QW-1:0]   w1_q;
  logic [QW-1:0]   w2a_q;
  alc_side_t       side1_q;

  assign prod_a = MulW'(in_data_i.w) * MulW'(in_data_i.w);

  always_ff @(posedge clk_i) begin
    if (rdy_chain[0]) begin
      w1_q    <= in_data_i.w;
      w2a_q   <= prod_a[FracBits +: QW];
      side1_q <= in_data_i.side;
    end
  end

  // stage 2: w3 = (w2*w) >> F
  logic [MulW-1:0] prod_b;
  logic [QW-1:0]   w2b_q;
  logic [QW-1:0]   w3_q;
  alc_side_t       side2_q;

  assign prod_b = MulW'(w2a_q) * MulW'(w1_q);

  always_ff @(posedge clk_i) begin
    if (rdy_chain[1]) begin
      w2b_q   <= w2a_q;
      w3_q    <= prod_b[FracBits +: QW];
      side2_q <= side1_q;
    end
  end

  // stage 3: 3*w2 - 2*w3, clamp to [0, 1.0], pick the weight
  logic [SW-1:0] tri_w2;
  logic [SW-1:0] dbl_w3;
  logic [SW-1:0] s_raw;
  logic [QW-1:0] s_sat;
  alc_out_t      out_d;
  alc_out_t      out_q;

  always_comb begin
    tri_w2 = (SW'(w2b_q) << 1) + SW'(w2b_q);
    dbl_w3 = SW'(w3_q) << 1;
    s_raw  = tri_w2 - dbl_w3;
    if (s_raw[SW-1]) begin
      s_sat = '0;
    end else if (s_raw > SW'(OneQ)) begin
      s_sat = OneQ;
    end else begin
      s_sat = s_raw[QW-1:0];
    end
    out_d.cycle_next = side2_q.cycle;
    out_d.finished   = side2_q.finished;
    if (!side2_q.auto_ramp) begin
      out_d.weight_next = side2_q.weight_now;
    end else if (side2_q.seq_zero) begin
      out_d.weight_next = '0;
    end else begin
      out_d.weight_next = s_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_chain[2]) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = rdy_chain[0];
  assign out_valid_o = v_q[SmStages-1];
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/anim_layer_cycle_advance.sv
// ----------------------------------------------------------------------------
// anim_layer_cycle_advance
// Advances one animation layer's cycle position per beat and recomputes
// its blend weight.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o/in_data_i carries one layer per beat;
//   output channel out_valid_o/out_ready_i/out_data_o returns one result per
//   input beat, in order. No state is kept between layers.
//   Pipeline: 4 advance stages, 16 divide stages at one quotient bit each and
//   3 smoothstep stages between an accepted input beat and out_valid_o, with
//   the result held in a registered output stage.
//   Throughput: one beat per cycle; every stage is a register with its own
//   valid bit, so a beat enters each cycle the pipeline can move.
//   Reset (rst_ni low) clears all valid bits; in_ready_o is high right after.
//   Receiver stall: out_valid_o holds with a stable result; upstream stages
//   keep filling their empty slots, so in_ready_o drops only once all 23
//   stages hold a beat. Nothing is dropped or repeated across a stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module anim_layer_cycle_advance (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  alc_pkg::alc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output alc_pkg::alc_out_t out_data_o
);
  import alc_pkg::*;

  // advance -> divider
  logic     adv_valid;
  logic     adv_ready;
  alc_div_t adv_data;
  // divider -> smoothstep
  logic     div_valid;
  logic     div_ready;
  alc_wgt_t div_data;

  // cycle advance, wrap/clamp, ramp operand select
  alc_advance u_advance (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (adv_valid),
    .out_ready_i (adv_ready),
    .out_data_o  (adv_data)
  );

  // ramp ratio, bit-per-stage restoring divide
  alc_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (adv_valid),
    .in_ready_o  (adv_ready),
    .in_data_i   (adv_data),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_data_o  (div_data)
  );

  // smoothstep shaping and output register
  alc_smooth u_smooth (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .in_data_i   (div_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // beats in flight, for checking only
  localparam int unsigned OccW = $clog2(PipeDepth + 1);

  logic            in_acc;
  logic            out_acc;
  logic [OccW-1:0] occ_d;
  logic [OccW-1:0] occ_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    occ_d = occ_q;
    if (in_acc && !out_acc) begin
      occ_d = occ_q + OccW'(1);
    end else if (!in_acc && out_acc) begin
      occ_d = occ_q - OccW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // input back-pressure only comes from a stalled, full pipeline
  `ASSERT_IMPLIES(a_stall_from_rx, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)
  // never more beats in flight than stages
  `ASSERT_IMPLIES(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= OccW'(PipeDepth))
  // a presented result belongs to an accepted input beat
  `ASSERT_IMPLIES(a_out_has_src, clk_i, rst_ni, out_valid_o, occ_q != '0)
  // an accepted beat is in flight the next cycle
  `ASSERT_NEXT(a_accept_kept, clk_i, rst_ni, in_acc, occ_q != '0)

endmodule
